>>> hw/rtl/ordered_list_delete_by_value_assert.svh
// ---------------------------------------------------------------------------
// ordered list assertion macros
// shared concurrent assertion forms for the ordered list block
// ---------------------------------------------------------------------------
`ifndef ORDERED_LIST_DELETE_BY_VALUE_ASSERT_SVH
`define ORDERED_LIST_DELETE_BY_VALUE_ASSERT_SVH

// same-cycle implication
`define OLDBV_ASSERT_NOW(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OLDBV_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/oldbv_pkg.sv
// ---------------------------------------------------------------------------
// ordered list package
// sizes, opcodes and status codes of the ordered list block
// ---------------------------------------------------------------------------
package oldbv_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = 7;
   localparam int VAL_W    = 17;
   localparam int OP_W     = 2;
   localparam int ST_W     = 3;

   localparam logic [VAL_W-1:0] MAX_VALUE_RESET = 17'd100000;

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [ST_W-1:0] ST_LARGE    = 3'd3;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd4;
   localparam logic [ST_W-1:0] ST_EMPTY    = 3'd5;

endpackage

>>> hw/rtl/oldbv_ram.sv
// ---------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module oldbv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ordered_list_delete_by_value.sv
// ---------------------------------------------------------------------------
// ordered list with delete by value
// arrival-ordered store with append, remove of first match and dump
// ---------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   req_valid/stall    req_opcode, req_value
//  rsp      out  rsp_valid/stall    rsp_value_res, rsp_status, rsp_last, rsp_count
//  csr      in   csr_wr_en          csr_wr_data (max_value)
//
// append checks the tail entry for a duplicate, remove scans then shifts, dump walks all entries,
// all through the single read port of the entry ram walked by the sequencer
// one beat leaves per cycle during a dump while rsp_stall is low
// a request is taken only when the sequencer is idle
// reset clears the state and count; the entry ram needs no clearing pass
// ---------------------------------------------------------------------------
module ordered_list_delete_by_value (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [oldbv_pkg::OP_W-1:0]   req_opcode,
   input  logic [oldbv_pkg::VAL_W-1:0]  req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [oldbv_pkg::VAL_W-1:0]  rsp_value_res,
   output logic [oldbv_pkg::ST_W-1:0]   rsp_status,
   output logic                         rsp_last,
   output logic [oldbv_pkg::CNT_W-1:0]  rsp_count,
   input  logic                         csr_wr_en,
   input  logic [oldbv_pkg::VAL_W-1:0]  csr_wr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_APP_CHK,
      S_REM_SCAN,
      S_REM_SHIFT,
      S_DUMP,
      S_RES
   } state_type;

   state_type                       state_ff, state_in;
   logic [oldbv_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [oldbv_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [oldbv_pkg::VAL_W-1:0]     max_ff, max_in;
   logic [oldbv_pkg::VAL_W-1:0]     val_ff, val_in;
   logic [oldbv_pkg::ST_W-1:0]      st_ff, st_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [oldbv_pkg::VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [oldbv_pkg::ST_W-1:0]      rsp_status_ff, rsp_status_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic [oldbv_pkg::CNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                            ram_we;
   logic [oldbv_pkg::IDX_W-1:0]     ram_waddr;
   logic [oldbv_pkg::VAL_W-1:0]     ram_wdata;
   logic                            ram_re;
   logic [oldbv_pkg::IDX_W-1:0]     ram_raddr;
   logic [oldbv_pkg::VAL_W-1:0]     ram_rdata;

   logic                            out_free;
   logic                            too_large;
   logic [oldbv_pkg::IDX_W-1:0]     idx_p1;
   logic [oldbv_pkg::IDX_W-1:0]     idx_p2;
   logic [oldbv_pkg::CNT_W-1:0]     cnt_m1;
   logic                            at_tail;
   logic                            more_shift;

   oldbv_ram #(
      .WIDTH (oldbv_pkg::VAL_W),
      .DEPTH (oldbv_pkg::CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign too_large  = req_value > max_ff;
   assign idx_p1     = idx_ff + oldbv_pkg::IDX_W'(1);
   assign idx_p2     = idx_ff + oldbv_pkg::IDX_W'(2);
   assign cnt_m1     = count_ff - oldbv_pkg::CNT_W'(1);
   assign at_tail    = (oldbv_pkg::CNT_W'(idx_ff) + oldbv_pkg::CNT_W'(1)) == count_ff;
   assign more_shift = (oldbv_pkg::CNT_W'(idx_ff) + oldbv_pkg::CNT_W'(2)) < count_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      max_in        = csr_wr_en ? csr_wr_data : max_ff;
      val_in        = val_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = req_value;
      ram_re        = 1'b0;
      ram_raddr     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in = req_value;
               idx_in = '0;
               unique case (req_opcode)
                  oldbv_pkg::OP_APPEND: begin
                     if (too_large) begin
                        st_in    = oldbv_pkg::ST_LARGE;
                        state_in = S_RES;
                     end else if (count_ff == '0) begin
                        ram_we   = 1'b1;
                        count_in = oldbv_pkg::CNT_W'(1);
                        st_in    = oldbv_pkg::ST_OK;
                        state_in = S_RES;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = cnt_m1[oldbv_pkg::IDX_W-1:0];
                        state_in  = S_APP_CHK;
                     end
                  end
                  oldbv_pkg::OP_REMOVE: begin
                     if (too_large) begin
                        st_in    = oldbv_pkg::ST_LARGE;
                        state_in = S_RES;
                     end else if (count_ff == '0) begin
                        st_in    = oldbv_pkg::ST_NOTFOUND;
                        state_in = S_RES;
                     end else begin
                        ram_re   = 1'b1;
                        state_in = S_REM_SCAN;
                     end
                  end
                  oldbv_pkg::OP_DUMP: begin
                     if (count_ff == '0) begin
                        val_in   = '0;
                        st_in    = oldbv_pkg::ST_EMPTY;
                        state_in = S_RES;
                     end else begin
                        ram_re   = 1'b1;
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_APP_CHK: begin
            state_in = S_RES;
            if (ram_rdata == val_ff) begin
               st_in = oldbv_pkg::ST_DUP;
            end else if (count_ff == oldbv_pkg::CNT_W'(oldbv_pkg::CAPACITY)) begin
               st_in = oldbv_pkg::ST_FULL;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = count_ff[oldbv_pkg::IDX_W-1:0];
               ram_wdata = val_ff;
               count_in  = count_ff + oldbv_pkg::CNT_W'(1);
               st_in     = oldbv_pkg::ST_OK;
            end
         end
         S_REM_SCAN: begin
            if (ram_rdata == val_ff) begin
               if (at_tail) begin
                  count_in = cnt_m1;
                  st_in    = oldbv_pkg::ST_OK;
                  state_in = S_RES;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = idx_p1;
                  state_in  = S_REM_SHIFT;
               end
            end else if (at_tail) begin
               st_in    = oldbv_pkg::ST_NOTFOUND;
               state_in = S_RES;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = idx_p1;
               idx_in    = idx_p1;
            end
         end
         S_REM_SHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = ram_rdata;
            idx_in    = idx_p1;
            if (more_shift) begin
               ram_re    = 1'b1;
               ram_raddr = idx_p2;
            end else begin
               count_in = cnt_m1;
               st_in    = oldbv_pkg::ST_OK;
               state_in = S_RES;
            end
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = ram_rdata;
               rsp_status_in = oldbv_pkg::ST_OK;
               rsp_last_in   = at_tail;
               rsp_count_in  = count_ff;
               if (at_tail) begin
                  state_in = S_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = idx_p1;
                  idx_in    = idx_p1;
               end
            end
         end
         S_RES: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = val_ff;
               rsp_status_in = st_ff;
               rsp_last_in   = 1'b1;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         max_ff       <= oldbv_pkg::MAX_VALUE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff        <= val_in;
      st_ff         <= st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall     = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_count     = rsp_count_ff;

`include "ordered_list_delete_by_value_assert.svh"

   `OLDBV_ASSERT_NOW(a_count_bound, 1'b1, (count_ff <= oldbv_pkg::CNT_W'(oldbv_pkg::CAPACITY)), "entry count above capacity")

   `OLDBV_ASSERT_NEXT(a_count_step, 1'b1, (count_ff == $past(count_ff) || count_ff == $past(count_ff) + 1 || count_ff == $past(count_ff) - 1), "entry count moved by more than one")

   `OLDBV_ASSERT_NOW(a_dump_continues, (rsp_valid_ff && !rsp_stall && !rsp_last_ff), (state_ff == S_DUMP), "beat without last but dump not running")

endmodule
